@@ rtl/priority_interrupt_controller_core_defines.svh @@
// Assertion macros shared by the priority interrupt controller RTL.
`ifndef PRIORITY_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pic assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pic assertion failed");

`endif

@@ rtl/pic_pkg.sv @@
// Shared types and constants of the priority interrupt controller.
package pic_pkg;

  localparam int NUM_LEVELS = 8;
  localparam int NUM_UNITS  = 64;
  localparam int LVL_IDX_W  = $clog2(NUM_LEVELS);
  localparam int UNIT_IDX_W = $clog2(NUM_UNITS);

  typedef enum logic [2:0] {
    ACT_RAISE   = 3'd0,
    ACT_DROP    = 3'd1,
    ACT_TAKE    = 3'd2,
    ACT_ACTIVE  = 3'd3,
    ACT_DEBREAK = 3'd4,
    ACT_ARM     = 3'd5,
    ACT_RESET   = 3'd6
  } pic_action_t;

  typedef struct packed {
    pic_action_t action;
    logic [2:0]  level;
    logic [5:0]  unit;
    logic [7:0]  level_mask;
    logic        arm_value;
  } pic_in_t;

  typedef struct packed {
    logic       pending_valid;
    logic [2:0] pending_level;
    logic       taken_valid;
    logic [5:0] taken_unit;
  } pic_out_t;

  typedef struct packed {
    logic [NUM_LEVELS-1:0][NUM_UNITS-1:0] requests;
    logic [NUM_LEVELS-1:0]                armed;
    logic [NUM_LEVELS-1:0]                active;
  } pic_state_t;

endpackage

@@ rtl/pic_update.sv @@
// Applies one request to the controller state and computes its result.
module pic_update (
  input  pic_pkg::pic_in_t    req,
  input  pic_pkg::pic_state_t cur,
  output pic_pkg::pic_state_t nxt,
  output pic_pkg::pic_out_t   res
);
  import pic_pkg::*;

  function automatic logic [UNIT_IDX_W-1:0] lowest_unit(input logic [NUM_UNITS-1:0] v);
    logic [UNIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_UNITS - 1; i >= 0; i--) begin
      if (v[i]) idx = UNIT_IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [LVL_IDX_W-1:0] lowest_level(input logic [NUM_LEVELS-1:0] v);
    logic [LVL_IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (v[i]) idx = LVL_IDX_W'(i);
    end
    return idx;
  endfunction

  logic                   level_ok;
  logic                   unit_ok;
  logic [LVL_IDX_W-1:0]   lvl_idx;
  logic [UNIT_IDX_W-1:0]  unit_idx;
  logic [NUM_LEVELS-1:0]  mask;
  logic [NUM_UNITS-1:0]   lvl_reqs;
  logic [UNIT_IDX_W-1:0]  take_idx;
  logic [NUM_LEVELS-1:0]  lowest_active;
  logic [NUM_LEVELS-1:0]  allowed;
  logic [NUM_LEVELS-1:0]  cand;
  logic                   taken_valid;
  logic [UNIT_IDX_W-1:0]  taken_unit;

  assign level_ok = (int'(req.level) < NUM_LEVELS);
  assign unit_ok  = (int'(req.unit) < NUM_UNITS);
  assign lvl_idx  = LVL_IDX_W'(req.level);
  assign unit_idx = UNIT_IDX_W'(req.unit);
  assign mask     = NUM_LEVELS'(req.level_mask);
  assign lvl_reqs = level_ok ? cur.requests[lvl_idx] : '0;
  assign take_idx = lowest_unit(lvl_reqs);

  always_comb begin
    nxt         = cur;
    taken_valid = 1'b0;
    taken_unit  = '0;
    unique case (req.action)
      ACT_RAISE: begin
        if (level_ok && unit_ok) nxt.requests[lvl_idx][unit_idx] = 1'b1;
      end
      ACT_DROP: begin
        if (level_ok && unit_ok) nxt.requests[lvl_idx][unit_idx] = 1'b0;
      end
      ACT_TAKE: begin
        if (|lvl_reqs) begin
          nxt.requests[lvl_idx][take_idx] = 1'b0;
          taken_valid = 1'b1;
          taken_unit  = take_idx;
        end
      end
      ACT_ACTIVE: begin
        if (level_ok) nxt.active[lvl_idx] = 1'b1;
      end
      ACT_DEBREAK: begin
        nxt.active = cur.active & (cur.active - NUM_LEVELS'(1));
      end
      ACT_ARM: begin
        nxt.armed = req.arm_value ? (cur.armed | mask) : (cur.armed & ~mask);
      end
      ACT_RESET: begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          if (mask[l]) nxt.requests[l] = '0;
        end
        nxt.active = cur.active & ~mask;
        nxt.armed  = cur.armed | mask;
      end
      default: begin
      end
    endcase
  end

  // Levels strictly below the lowest active one may interrupt; with none active, all levels may.
  assign lowest_active = nxt.active & (~nxt.active + NUM_LEVELS'(1));
  assign allowed       = lowest_active - NUM_LEVELS'(1);

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      cand[l] = nxt.armed[l] & (|nxt.requests[l]) & allowed[l];
    end
  end

  assign res = {(|cand), ((|cand) ? 3'(lowest_level(cand)) : 3'd0),
                taken_valid, 6'(taken_unit)};

endmodule

@@ rtl/priority_interrupt_controller_core.sv @@
// Top level of the priority interrupt controller: request and result registers.
// A request accepted at one clock edge is held in in_r, its result is registered
// in out_r, and out_valid is raised together with that registered result.
// One request can be accepted every cycle; busy is never raised.
// Synchronous active-low reset clears all requests, armed and active flags.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "priority_interrupt_controller_core_defines.svh"

module priority_interrupt_controller_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pic_pkg::pic_in_t  in_data,
  output logic              out_valid,
  output pic_pkg::pic_out_t out_data
);
  import pic_pkg::*;

  logic       in_valid_r;
  pic_in_t    in_r;
  pic_state_t state_r;
  pic_state_t state_nxt;
  logic       out_valid_r;
  pic_out_t   out_r;
  pic_out_t   out_nxt;

  assign busy = 1'b0;

  pic_update u_update (
    .req (in_r),
    .cur (state_r),
    .nxt (state_nxt),
    .res (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r       <= '0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
      if (in_valid_r) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) in_r <= in_data;
    if (in_valid_r) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PIC_ASSERT_NEXT(a_strobe_follows, clk, rst_n, in_valid_r, out_valid_r)
  `PIC_ASSERT_NEXT(a_take_only, clk, rst_n, in_valid_r && (in_r.action != ACT_TAKE), !out_r.taken_valid)
  `PIC_ASSERT_SAME(a_pending_armed, clk, rst_n, out_valid_r && out_r.pending_valid, |state_r.armed)
  `PIC_ASSERT_NEXT(a_reset_arms, clk, rst_n, in_valid_r && (in_r.action == ACT_RESET), (state_r.armed & NUM_LEVELS'($past(in_r.level_mask))) == NUM_LEVELS'($past(in_r.level_mask)))

endmodule
